FILE: hw/rtl/gmdcp_pkg.sv
// Shared constants, register codes and control structures of the minimum-distance cell picker.
`timescale 1ns / 1ps
`default_nettype none

package gmdcp_pkg;

  // Grid size.
  localparam int ROWS = 256;
  localparam int COLS = 256;

  // Cell store geometry.
  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Coordinate and walk-offset width; holds any offset up to 4096 plus a start index.
  localparam int CW = 13;

  // Field and register widths.
  localparam int IDX_W    = 8;
  localparam int STEP_W   = 24;
  localparam int LIM_W    = 48;
  localparam int CNT_W    = 17;
  localparam int CFG_W    = 48;
  localparam int CFG_IX_W = 2;

  // Distance arithmetic widths.
  localparam int PROD_W = STEP_W + CW;
  localparam int DIST_W = 32;
  localparam int SQ_W   = 64;

  // Item modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PICK = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IX_W-1:0] {
    REG_ROW_STEP  = 2'd0,
    REG_COL_STEP  = 2'd1,
    REG_LIMIT     = 2'd2,
    REG_MAX_PICKS = 2'd3
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;    // clear one cell of the store, advance the sweep
    logic capture;     // latch the input beat
    logic item_rd;     // read the cell named by the item
    logic load_apply;  // write the item's flag, keep the count exact
    logic pick_apply;  // take the candidate, start the first quadrant
    logic next_quad;   // move to the next quadrant
    logic next_row;    // move to the next row of the quadrant
    logic row_mul;     // distance along rows
    logic row_sq;      // square of the row distance
    logic col_init;    // first column of the row
    logic col_mul;     // distance along columns
    logic col_sq;      // square of the column distance
    logic cell_wr;     // clear the walked cell if set, next column
    logic res_load;    // load the result registers
    logic res_chosen;  // the result reports a chosen cell
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic in_grid;
    logic is_pick;
    logic can_pick;
    logic cell_set;
    logic row_ok;
    logic rsq_over;
    logic col_ok;
    logic tot_over;
    logic last_quad;
  } dp_stat_t;

  // Linear store address of a cell.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] r,
                                                  input logic [CW-1:0] c);
    logic [31:0] lin;
    lin = 32'(r) * 32'(COLS) + 32'(c);
    return lin[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gmdcp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gmdcp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gmdcp_ctrl.sv
// Controller state machine of the minimum-distance cell picker.
`timescale 1ns / 1ps
`default_nettype none

module gmdcp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  gmdcp_pkg::dp_stat_t stat,
  output gmdcp_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  import gmdcp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_LOOK_WAIT,
    S_ROW,
    S_RSQ,
    S_RCHK,
    S_COL,
    S_CSQ,
    S_CCHK,
    S_CWR
  } state_t;

  state_t state;
  state_t state_next;
  logic   fin;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    fin        = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!stat.in_grid) begin
          cmd.res_load = 1'b1;
          fin          = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.item_rd = 1'b1;
          state_next  = S_LOOK_WAIT;
        end
      end
      S_LOOK_WAIT: begin
        if (!stat.is_pick) begin
          cmd.load_apply = 1'b1;
          cmd.res_load   = 1'b1;
          fin            = 1'b1;
          state_next     = S_IDLE;
        end else if (stat.can_pick && stat.cell_set) begin
          cmd.pick_apply = 1'b1;
          state_next     = S_ROW;
        end else begin
          cmd.res_load = 1'b1;
          fin          = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ROW: begin
        if (stat.row_ok) begin
          cmd.row_mul = 1'b1;
          state_next  = S_RSQ;
        end else if (stat.last_quad) begin
          cmd.res_load   = 1'b1;
          cmd.res_chosen = 1'b1;
          fin            = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.next_quad = 1'b1;
          state_next    = S_ROW;
        end
      end
      S_RSQ: begin
        cmd.row_sq = 1'b1;
        state_next = S_RCHK;
      end
      S_RCHK: begin
        if (!stat.rsq_over) begin
          cmd.col_init = 1'b1;
          state_next   = S_COL;
        end else if (stat.last_quad) begin
          cmd.res_load   = 1'b1;
          cmd.res_chosen = 1'b1;
          fin            = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.next_quad = 1'b1;
          state_next    = S_ROW;
        end
      end
      S_COL: begin
        if (stat.col_ok) begin
          cmd.col_mul = 1'b1;
          state_next  = S_CSQ;
        end else begin
          cmd.next_row = 1'b1;
          state_next   = S_ROW;
        end
      end
      S_CSQ: begin
        cmd.col_sq = 1'b1;
        state_next = S_CCHK;
      end
      S_CCHK: begin
        if (stat.tot_over) begin
          cmd.next_row = 1'b1;
          state_next   = S_ROW;
        end else begin
          state_next = S_CWR;
        end
      end
      S_CWR: begin
        cmd.cell_wr = 1'b1;
        state_next  = S_COL;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= fin;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gmdcp_dp.sv
// Datapath of the minimum-distance cell picker: registers, counters, distance units, cell store.
`timescale 1ns / 1ps
`default_nettype none

module gmdcp_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                mode,
  input  logic [gmdcp_pkg::IDX_W-1:0]         row,
  input  logic [gmdcp_pkg::IDX_W-1:0]         col,
  input  logic                                flag_value,
  input  logic                                cfg_we,
  input  logic [gmdcp_pkg::CFG_IX_W-1:0]      cfg_index,
  input  logic [gmdcp_pkg::CFG_W-1:0]         cfg_data,
  input  gmdcp_pkg::dp_cmd_t                  cmd,
  output gmdcp_pkg::dp_stat_t                 stat,
  output logic [gmdcp_pkg::CNT_W-1:0]         label,
  output logic                                chosen,
  output logic [gmdcp_pkg::CNT_W-1:0]         remaining,
  output logic                                finished
);

  import gmdcp_pkg::*;

  // Configuration registers.
  logic [STEP_W-1:0] row_step;
  logic [STEP_W-1:0] col_step;
  logic [LIM_W-1:0]  limit_dist_sq;
  logic [CNT_W-1:0]  max_picks;

  // Item and walk registers.
  logic              it_mode;
  logic              it_flag;
  logic [CW-1:0]     r0;
  logic [CW-1:0]     c0;
  logic [1:0]        quad;
  logic [CW-1:0]     kr;
  logic [CW-1:0]     kc;
  logic              d_sat;
  logic [DIST_W-1:0] d_lo;
  logic [SQ_W-1:0]   rsq;
  logic [SQ_W-1:0]   csq;
  logic [ADDR_W-1:0] clr_addr;
  logic [CNT_W-1:0]  remaining_count;
  logic [CNT_W-1:0]  picks_made;

  logic [CNT_W-1:0]  remaining_next;
  logic [CNT_W-1:0]  picks_next;
  logic [CW-1:0]     cur_r;
  logic [CW-1:0]     cur_c;
  logic [ADDR_W-1:0] item_addr;
  logic [ADDR_W-1:0] walk_addr;
  logic [STEP_W-1:0] mul_step;
  logic [CW-1:0]     mul_k;
  logic [PROD_W-1:0] prod;
  logic [SQ_W-1:0]   sq;
  logic [SQ_W-1:0]   lim_ext;
  logic [SQ_W:0]     tot;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_rdata;

  // Cell under the walk; quad bit 0 walks rows upwards, bit 1 walks columns leftwards.
  assign cur_r     = quad[0] ? (r0 - kr) : (r0 + kr);
  assign cur_c     = quad[1] ? (c0 - kc) : (c0 + kc);
  assign item_addr = cell_addr(r0, c0);
  assign walk_addr = cell_addr(cur_r, cur_c);

  // Shared step multiplier: distance is the step times the offset, saturating above 32 bits.
  assign mul_step = cmd.col_mul ? col_step : row_step;
  assign mul_k    = cmd.col_mul ? kc : kr;
  assign prod     = PROD_W'(mul_step) * PROD_W'(mul_k);

  // Shared squarer on the registered distance.
  assign sq = d_sat ? {SQ_W{1'b1}} : (SQ_W'(d_lo) * SQ_W'(d_lo));

  // Sum of the two squares with a carry bit, against the limit; a carry is always outside.
  assign lim_ext = SQ_W'(limit_dist_sq);
  assign tot     = {1'b0, rsq} + {1'b0, csq};

  // Status towards the controller.
  always_comb begin
    stat.clr_last  = (clr_addr == ADDR_W'(DEPTH - 1));
    stat.in_grid   = (r0 < CW'(ROWS)) && (c0 < CW'(COLS));
    stat.is_pick   = (it_mode == MODE_PICK);
    stat.can_pick  = (picks_made < max_picks);
    stat.cell_set  = mem_rdata;
    stat.row_ok    = quad[0] ? (kr <= r0) : ((r0 + kr) < CW'(ROWS));
    stat.rsq_over  = (rsq > lim_ext);
    stat.col_ok    = quad[1] ? (kc <= c0) : ((c0 + kc) < CW'(COLS));
    stat.tot_over  = tot[SQ_W] || (tot[SQ_W-1:0] > lim_ext);
    stat.last_quad = (quad == 2'd3);
  end

  // Cell store port selection.
  always_comb begin
    mem_we    = cmd.clr_step || cmd.load_apply || (cmd.cell_wr && mem_rdata);
    mem_waddr = cmd.clr_step ? clr_addr : (cmd.load_apply ? item_addr : walk_addr);
    mem_wdata = cmd.load_apply ? it_flag : 1'b0;
    mem_raddr = cmd.item_rd ? item_addr : walk_addr;
  end

  // Counts after this cycle.
  always_comb begin
    remaining_next = remaining_count;
    if (cmd.load_apply) begin
      if (it_flag && !mem_rdata) begin
        remaining_next = remaining_count + CNT_W'(1);
      end else if (!it_flag && mem_rdata) begin
        remaining_next = remaining_count - CNT_W'(1);
      end
    end else if (cmd.cell_wr && mem_rdata) begin
      remaining_next = remaining_count - CNT_W'(1);
    end
    picks_next = cmd.pick_apply ? (picks_made + CNT_W'(1)) : picks_made;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_step      <= STEP_W'(256);
      col_step      <= STEP_W'(256);
      limit_dist_sq <= LIM_W'(65536);
      max_picks     <= CNT_W'(65536);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_STEP:  row_step      <= cfg_data[STEP_W-1:0];
        REG_COL_STEP:  col_step      <= cfg_data[STEP_W-1:0];
        REG_LIMIT:     limit_dist_sq <= cfg_data[LIM_W-1:0];
        REG_MAX_PICKS: max_picks     <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Counters and sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr        <= '0;
      remaining_count <= '0;
      picks_made      <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      remaining_count <= remaining_next;
      picks_made      <= picks_next;
    end
  end

  // Item beat and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode <= mode;
      it_flag <= flag_value;
      r0      <= CW'(row);
      c0      <= CW'(col);
    end
    if (cmd.pick_apply) begin
      quad <= 2'd0;
      kr   <= '0;
    end else if (cmd.next_quad) begin
      quad <= quad + 2'd1;
      kr   <= {{(CW-1){1'b0}}, ~quad[0]};
    end else if (cmd.next_row) begin
      kr <= kr + CW'(1);
    end
    if (cmd.col_init) begin
      kc <= CW'(quad[1]);
    end else if (cmd.cell_wr) begin
      kc <= kc + CW'(1);
    end
    if (cmd.row_mul || cmd.col_mul) begin
      d_sat <= |prod[PROD_W-1:DIST_W];
      d_lo  <= prod[DIST_W-1:0];
    end
    if (cmd.row_sq) begin
      rsq <= sq;
    end
    if (cmd.col_sq) begin
      csq <= sq;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      label     <= cmd.res_chosen ? picks_next : '0;
      chosen    <= cmd.res_chosen;
      remaining <= remaining_next;
      finished  <= (remaining_next == '0) || (picks_next >= max_picks);
    end
  end

  // Eligibility bitmap, one bit per cell.
  gmdcp_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/grid_min_distance_cell_picker.sv
// Top level of the minimum-distance cell picker: controller, datapath and cell store.
//
//   Channel   Handshake                  Payload
//   item in   start, busy (accept when   mode, row, col, flag_value
//             start high and busy low)
//   result    done (one-cycle strobe)    label, chosen, remaining, finished
//   config    cfg_we                     cfg_index, cfg_data
//
// After reset a sweep clears the bitmap, one cell a cycle; busy stays high during it and
// configuration writes are still taken. A load item or a refused candidate reads its cell
// before its result beat; an item outside the grid gets its result without the read. For a
// chosen cell the picker then walks each quadrant row by row and cell by cell, finding each
// row's end and the quadrant's end. The receiver cannot stall; done is high for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module grid_min_distance_cell_picker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode,
  input  logic [gmdcp_pkg::IDX_W-1:0]    row,
  input  logic [gmdcp_pkg::IDX_W-1:0]    col,
  input  logic                           flag_value,
  input  logic                           cfg_we,
  input  logic [gmdcp_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [gmdcp_pkg::CFG_W-1:0]    cfg_data,
  output logic                           done,
  output logic [gmdcp_pkg::CNT_W-1:0]    label,
  output logic                           chosen,
  output logic [gmdcp_pkg::CNT_W-1:0]    remaining,
  output logic                           finished
);

  import gmdcp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer of the walk.
  gmdcp_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  // Registers, arithmetic and bitmap.
  gmdcp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .row       (row),
    .col       (col),
    .flag_value(flag_value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .label     (label),
    .chosen    (chosen),
    .remaining (remaining),
    .finished  (finished)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/gmdcp_checker.sv
// Port-level assertions for the minimum-distance cell picker and their binding.
`timescale 1ns / 1ps
`default_nettype none

module gmdcp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [gmdcp_pkg::CNT_W-1:0]    label,
  input logic                           chosen,
  input logic [gmdcp_pkg::CNT_W-1:0]    remaining,
  input logic                           finished
);

  // An accepted beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // Results never come back to back, so the result strobe is high for a single cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // A result without a chosen cell carries label zero.
  a_label_zero: assert property (@(posedge clk) disable iff (rst)
    done && !chosen |-> label == '0)
    else $error("label set on a refused item");

  // A chosen cell always gets a non-zero label.
  a_label_set: assert property (@(posedge clk) disable iff (rst)
    done && chosen |-> label != '0)
    else $error("chosen cell with label zero");

  // No eligible cells left means the picker reports finished.
  a_empty_finished: assert property (@(posedge clk) disable iff (rst)
    done && (remaining == '0) |-> finished)
    else $error("empty bitmap not reported as finished");

endmodule

bind grid_min_distance_cell_picker gmdcp_checker u_gmdcp_checker (.*);

`default_nettype wire
